/* hdl/dlcf_pkg.sv */
// ----------------------------------------------------------------------------
// dlcf_pkg
// shared types, codes and sizes of the display list cull filter
// ----------------------------------------------------------------------------
`default_nettype none

package dlcf_pkg;

	localparam int TARGET_DEPTH = 256;
	localparam int SCOPE_DEPTH  = 64;
	localparam int OFF_W        = 24;

	localparam int TA_W  = $clog2(TARGET_DEPTH);
	localparam int PTR_W = TA_W + 1;
	localparam int SA_W  = $clog2(SCOPE_DEPTH);
	localparam int LVL_W = $clog2(SCOPE_DEPTH + 1);

	localparam int ACT_W  = 2;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	localparam int IN_FIELDS_W  = 2 * OFF_W + KIND_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + STAT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [OFF_W-1:0] SENTINEL = '1;

	localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CMD   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] OP_SAVE    = 3'd0;
	localparam logic [KIND_W-1:0] OP_RESTORE = 3'd1;
	localparam logic [KIND_W-1:0] OP_XFORM   = 3'd2;
	localparam logic [KIND_W-1:0] OP_DRAW    = 3'd3;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_STK_OVF = 2'd1;
	localparam logic [STAT_W-1:0] ST_Q_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

	typedef enum logic [1:0] {
		IT_PUSH,
		IT_CMD,
		IT_CLEAR,
		IT_NOP
	} item_kind_t;

	typedef struct packed {
		item_kind_t        kind;
		logic [OFF_W-1:0]  offset;
		logic [KIND_W-1:0] op_kind;
		logic [OFF_W-1:0]  rest_off;
	} item_t;

	typedef struct packed {
		logic [OFF_W-1:0] prev_end;
		logic [OFF_W-1:0] restore_at;
		logic             was_replayed;
	} scope_t;

	typedef struct packed {
		logic              valid;
		logic              replay;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

`default_nettype wire

/* hdl/display_list_cull_filter.sv */
// ----------------------------------------------------------------------------
// display_list_cull_filter
// replay filter for recorded drawing commands under a cull area
// ----------------------------------------------------------------------------
// channel    dir  word                          fields (low bit up)
// s_axis     in   target push, command, clear   tuser: action
//                                               tdata: offset, op_kind, restore offset
// m_axis     out  one result per input word     tdata: replay, status
// cfg        in   register write                cfg_wdata: cull_enable
//
// target pushes, clears and unfiltered commands are done in the engine's idle state
// a filtered command then passes through the judge state, which drops stale targets
// one at a time, using the registered read of the target queue memory
// the two-entry input queue accepts until full while the result register waits
// reset empties the target queue and the scope stack and sets cull_enable
// ----------------------------------------------------------------------------
`default_nettype none

module display_list_cull_filter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// offset, op_kind, restore offset, zero pad
	input  wire logic [dlcf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// action
	input  wire logic [dlcf_pkg::ACT_W-1:0]         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// replay, status, zero pad
	output logic [dlcf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_wdata
);
	import dlcf_pkg::*;

	logic    cull_enable_q;
	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_enable_q <= 1'b1;
		end else if (cfg_we) begin
			cull_enable_q <= cfg_wdata;
		end
	end

	dlcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_action   (s_axis_tuser),
		.s_offset   (s_axis_tdata[OFF_W-1:0]),
		.s_op_kind  (s_axis_tdata[OFF_W+KIND_W-1:OFF_W]),
		.s_rest_off (s_axis_tdata[2*OFF_W+KIND_W-1:OFF_W+KIND_W]),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	dlcf_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cull_enable (cull_enable_q),
		.in_valid    (q_valid),
		.in_item     (q_item),
		.in_pop      (q_pop),
		.res         (res),
		.res_ready   (m_axis_tready)
	);

	assign m_axis_tvalid = res.valid;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res.status, res.replay};

endmodule

`default_nettype wire

/* hdl/dlcf_front.sv */
// ----------------------------------------------------------------------------
// dlcf_front
// accepts input words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module dlcf_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_valid,
	output logic                              s_ready,
	input  wire logic [dlcf_pkg::ACT_W-1:0]   s_action,
	input  wire logic [dlcf_pkg::OFF_W-1:0]   s_offset,
	input  wire logic [dlcf_pkg::KIND_W-1:0]  s_op_kind,
	input  wire logic [dlcf_pkg::OFF_W-1:0]   s_rest_off,
	output logic                              q_valid,
	output dlcf_pkg::item_t                   q_item,
	input  wire logic                         q_pop
);
	import dlcf_pkg::*;

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      new_item;
	logic       push;
	logic       pop;

	always_comb begin
		new_item.offset   = s_offset;
		new_item.op_kind  = s_op_kind;
		new_item.rest_off = s_rest_off;
		case (s_action)
			ACT_PUSH:  new_item.kind = IT_PUSH;
			ACT_CMD:   new_item.kind = IT_CMD;
			ACT_CLEAR: new_item.kind = IT_CLEAR;
			default:   new_item.kind = IT_NOP;
		endcase
	end

	assign s_ready = count_q != 2'd2;
	assign q_valid = count_q != 2'd0;
	assign q_item  = fifo_q[rd_ptr_q];
	assign push    = s_valid && s_ready;
	assign pop     = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/dlcf_engine.sv */
// ----------------------------------------------------------------------------
// dlcf_engine
// executes queued words against the target queue and the save scope stack
// ----------------------------------------------------------------------------
`default_nettype none

module dlcf_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cull_enable,
	input  wire logic            in_valid,
	input  wire dlcf_pkg::item_t in_item,
	output logic                 in_pop,
	output dlcf_pkg::result_t    res,
	input  wire logic            res_ready
);
	import dlcf_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_JUDGE
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [OFF_W-1:0]   scope_end_q;
	logic [LVL_W-1:0]   level_q;
	logic [OFF_W-1:0]   off_q;
	logic [KIND_W-1:0]  kind_q;
	logic [OFF_W-1:0]   rest_q;
	result_t            res_q;

	logic [OFF_W-1:0]   tq_mem [TARGET_DEPTH];
	logic [OFF_W-1:0]   tq_rdata_q;
	logic [TA_W-1:0]    tq_raddr;
	logic               tq_we;
	scope_t             stk_mem [SCOPE_DEPTH];
	scope_t             stk_rdata_q;
	logic [SA_W-1:0]    stk_raddr;
	logic               stk_we;
	scope_t             stk_wdata;

	logic [PTR_W-1:0]   count;
	logic [PTR_W-1:0]   head_inc;
	logic               have;
	logic               stale;
	logic               out_free;
	logic               take;
	logic [OFF_W-1:0]   next_tgt;
	logic               need;
	logic               stk_full;
	logic [LVL_W-1:0]   level_dec;
	logic               restore_hit;
	logic               draw_hit;
	logic               res_set;
	logic               res_replay;
	logic [STAT_W-1:0]  res_status;

	always_comb begin
		count       = tail_q - head_q;
		head_inc    = head_q + PTR_W'(1);
		have        = count != '0;
		stale       = have && (off_q > tq_rdata_q);
		next_tgt    = have ? tq_rdata_q : SENTINEL;
		need        = next_tgt < rest_q;
		stk_full    = level_q >= LVL_W'(SCOPE_DEPTH);
		level_dec   = level_q - LVL_W'(1);
		restore_hit = (level_q != '0) && (stk_rdata_q.restore_at == off_q);
		draw_hit    = have && (off_q == next_tgt);
		out_free    = !res_q.valid || res_ready;
		take        = (state_q == S_IDLE) && in_valid && out_free;
		tq_raddr  = (state_q == S_JUDGE && stale) ? head_inc[TA_W-1:0] : head_q[TA_W-1:0];
		stk_raddr = level_dec[SA_W-1:0];
		tq_we     = take && (in_item.kind == IT_PUSH) && !count[PTR_W-1];
		stk_we    = (state_q == S_JUDGE) && !stale && (kind_q == OP_SAVE) && !stk_full;
		stk_wdata.prev_end     = scope_end_q;
		stk_wdata.restore_at   = rest_q;
		stk_wdata.was_replayed = need;
	end

	// result word of the current step
	always_comb begin
		res_set    = 1'b0;
		res_replay = 1'b0;
		res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (in_item.kind)
						IT_PUSH: begin
							res_set = 1'b1;
							if (count[PTR_W-1]) begin
								res_status = ST_Q_FULL;
							end
						end
						IT_CMD: begin
							res_set    = !cull_enable;
							res_replay = !cull_enable;
						end
						default: begin
							res_set = 1'b1;
						end
					endcase
				end
			end
			S_JUDGE: begin
				if (!stale) begin
					res_set = 1'b1;
					case (kind_q)
						OP_SAVE: begin
							if (stk_full) begin
								res_status = ST_STK_OVF;
							end else begin
								res_replay = need;
							end
						end
						OP_RESTORE: res_replay = restore_hit && stk_rdata_q.was_replayed;
						OP_XFORM:   res_replay = next_tgt < scope_end_q;
						OP_DRAW:    res_replay = draw_hit;
						default:    res_replay = 1'b0;
					endcase
				end
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	assign in_pop = take;
	assign res    = res_q;

	// target queue and scope stack
	always_ff @(posedge clk) begin
		if (tq_we) begin
			tq_mem[tail_q[TA_W-1:0]] <= in_item.offset;
		end
		tq_rdata_q <= tq_mem[tq_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[level_q[SA_W-1:0]] <= stk_wdata;
		end
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			scope_end_q <= SENTINEL;
			level_q     <= '0;
			off_q       <= '0;
			kind_q      <= '0;
			rest_q      <= '0;
			res_q       <= '0;
		end else begin
			if (res_set) begin
				res_q <= '{valid: 1'b1, replay: res_replay, status: res_status};
			end else if (res_q.valid && res_ready) begin
				res_q.valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (in_item.kind)
							IT_PUSH: begin
								if (!count[PTR_W-1]) begin
									tail_q <= tail_q + PTR_W'(1);
								end
							end
							IT_CLEAR: begin
								head_q      <= '0;
								tail_q      <= '0;
								scope_end_q <= SENTINEL;
								level_q     <= '0;
							end
							IT_CMD: begin
								if (cull_enable) begin
									off_q   <= in_item.offset;
									kind_q  <= in_item.op_kind;
									rest_q  <= in_item.rest_off;
									state_q <= S_JUDGE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_JUDGE: begin
					if (stale) begin
						head_q <= head_inc;
					end else begin
						state_q <= S_IDLE;
						case (kind_q)
							OP_SAVE: begin
								if (!stk_full) begin
									level_q     <= level_q + LVL_W'(1);
									scope_end_q <= rest_q;
								end
							end
							OP_RESTORE: begin
								if (restore_hit) begin
									level_q     <= level_dec;
									scope_end_q <= stk_rdata_q.prev_end;
								end
							end
							OP_DRAW: begin
								if (draw_hit) begin
									head_q <= head_inc;
								end
							end
							default: begin
								level_q <= level_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/dlcf_checker.sv */
// ----------------------------------------------------------------------------
// dlcf_checker
// port-level checks on the result channel of the cull filter
// ----------------------------------------------------------------------------
`default_nettype none

module dlcf_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [dlcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import dlcf_pkg::*;

	logic [STAT_W-1:0] status;
	logic              replay;

	assign replay = m_axis_tdata[0];
	assign status = m_axis_tdata[STAT_W:1];

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> status != ST_UNUSED)
		else $error("undefined status code");

	// a flagged word is never replayed
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status != ST_OK |-> !replay)
		else $error("replay set on a dropped word");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
		else $error("nonzero pad bits in result word");

endmodule

bind display_list_cull_filter dlcf_checker u_dlcf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/dlcf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcf_scoreboard
// watches the input, output and register channels of the cull filter, keeps
// its own copy of the target queue and the save scope stack, predicts replay
// and status for every accepted word and compares them with the results
// ----------------------------------------------------------------------------

module dlcf_scoreboard (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	input  wire logic [dlcf_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire logic [dlcf_pkg::ACT_W-1:0]         s_tuser,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic [dlcf_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_wdata,
	output int                                      mismatches,
	output int                                      pending
);
	import dlcf_pkg::*;

	typedef struct packed {
		logic              replay;
		logic [STAT_W-1:0] status;
	} outcome_t;

	logic              cull_on;
	logic [OFF_W-1:0]  targets[$];
	scope_t            scopes[SCOPE_DEPTH];
	int                level;
	logic [OFF_W-1:0]  cur_end;
	outcome_t          expected_outcomes[$];
	outcome_t          want;
	outcome_t          got;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic outcome_t judge_command(input logic [OFF_W-1:0] off,
			input logic [KIND_W-1:0] op, input logic [OFF_W-1:0] rest);
		outcome_t         res;
		logic [OFF_W-1:0] nxt;
		logic             hit;
		res = '0;
		// drop targets that lie behind this command
		while (targets.size() != 0 && off > targets[0])
			void'(targets.pop_front());
		hit = targets.size() != 0;
		nxt = hit ? targets[0] : SENTINEL;
		case (op)
			OP_SAVE: begin
				if (level >= SCOPE_DEPTH) begin
					res.status = ST_STK_OVF;
				end else begin
					scopes[level].prev_end = cur_end;
					scopes[level].restore_at = rest;
					scopes[level].was_replayed = nxt < rest;
					level++;
					cur_end = rest;
					res.replay = nxt < rest;
				end
			end
			OP_RESTORE: begin
				if (level != 0 && scopes[level-1].restore_at == off) begin
					res.replay = scopes[level-1].was_replayed;
					cur_end = scopes[level-1].prev_end;
					level--;
				end
			end
			OP_XFORM: res.replay = nxt < cur_end;
			OP_DRAW: begin
				if (hit && off == nxt) begin
					void'(targets.pop_front());
					res.replay = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic outcome_t predict_outcome(input logic [ACT_W-1:0] act,
			input logic [OFF_W-1:0] off, input logic [KIND_W-1:0] op,
			input logic [OFF_W-1:0] rest);
		outcome_t res;
		res = '0;
		case (act)
			ACT_PUSH: begin
				if (targets.size() >= TARGET_DEPTH)
					res.status = ST_Q_FULL;
				else
					targets.insert(targets.size(), off);
			end
			ACT_CMD: begin
				if (!cull_on)
					res.replay = 1'b1;
				else
					res = judge_command(off, op, rest);
			end
			ACT_CLEAR: begin
				targets.delete();
				cur_end = SENTINEL;
				level = 0;
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			cull_on = 1'b1;
			targets.delete();
			cur_end = SENTINEL;
			level = 0;
			expected_outcomes.delete();
		end else begin
			// results first: a word cannot leave at the edge it enters
			if (m_tvalid && m_tready) begin
				got.replay = m_tdata[0];
				got.status = m_tdata[1 +: STAT_W];
				if (expected_outcomes.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result word with nothing expected: replay %0d status %0d",
							$realtime, got.replay, got.status);
					mismatches++;
				end else begin
					want = expected_outcomes.pop_front();
					if (got.replay !== want.replay || got.status !== want.status) begin
						if (mismatches < 10)
							$display("%0t: mismatch: replay exp %0d got %0d, status exp %0d got %0d",
								$realtime, want.replay, got.replay, want.status, got.status);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				cull_on = cfg_wdata;
			if (s_tvalid && s_tready)
				expected_outcomes.insert(expected_outcomes.size(),
					predict_outcome(s_tuser, s_tdata[0 +: OFF_W],
					s_tdata[OFF_W +: KIND_W], s_tdata[OFF_W+KIND_W +: OFF_W]));
		end
		pending = expected_outcomes.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the cull filter with short directed display lists and then random
// ones (nested scopes, target queues, overflow cases, noise words) under
// changing cull settings, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------

module testbench;
	import dlcf_pkg::*;

	localparam logic [ACT_W-1:0]  ACT_IGNORED = IT_NOP;
	localparam logic [KIND_W-1:0] OP_OTHER    = 3'd4;
	localparam logic [KIND_W-1:0] OP_TOP_CODE = 3'd7;
	localparam logic [OFF_W-1:0]  OFF_MAX     = SENTINEL - 1'b1;
	localparam int                WORD_GOAL   = 1030;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [ACT_W-1:0]        s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_we = 1'b0;
	logic                    cfg_wdata = 1'b0;
	int                      mismatches;
	int                      pending;

	int   words_sent = 0;
	int   burst_left = 0;
	int   rx_mode = 0;
	int   rx_left = 0;
	int   hold_left = 0;
	logic hold_go = 1'b0;
	logic hold_taken = 1'b0;

	always #5 clk = ~clk;

	display_list_cull_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	dlcf_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(8, 80);
			end
			rx_left--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ~m_axis_tready;
			endcase
		end
	end

	task automatic put_word(input logic [ACT_W-1:0] act, input logic [OFF_W-1:0] off,
			input logic [KIND_W-1:0] op, input logic [OFF_W-1:0] rest);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= IN_TDATA_W'({rest, op, off});
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic put_command(input logic [OFF_W-1:0] off, input logic [KIND_W-1:0] op,
			input logic [OFF_W-1:0] rest);
		put_word(ACT_CMD, off, op, rest);
	endtask

	task automatic put_noise();
		put_word(2'($urandom_range(0, 3)), 24'($urandom_range(0, OFF_MAX)),
			3'($urandom_range(0, 7)), 24'($urandom_range(0, OFF_MAX)));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_cull(input logic value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// clear, queue the targets, then replay a well-formed list of commands with an occasional noise word mixed in
	task automatic run_list(input int n, input bit deep);
		logic [KIND_W-1:0] kinds[$];
		logic [OFF_W-1:0]  offs[$];
		logic [OFF_W-1:0]  rests[$];
		logic [OFF_W-1:0]  tgts[$];
		int                close_at[$];
		int                open_saves[$];
		int                depth;
		int                r;
		int                j;
		logic [KIND_W-1:0] k;
		logic [OFF_W-1:0]  cur;
		depth = 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (deep)
				k = (i < n / 2) ? OP_SAVE : OP_RESTORE;
			else if (r < 18 && depth < 10)
				k = OP_SAVE;
			else if (r < 36 && depth > 0)
				k = OP_RESTORE;
			else if (r < 65)
				k = OP_DRAW;
			else if (r < 80)
				k = OP_XFORM;
			else if (r < 95)
				k = OP_OTHER;
			else
				k = 3'($urandom_range(OP_OTHER + 1, OP_TOP_CODE));
			kinds.insert(kinds.size(), k);
			close_at.insert(close_at.size(), -1);
			if (k == OP_SAVE) begin
				open_saves.insert(open_saves.size(), i);
				depth++;
			end else if (k == OP_RESTORE) begin
				j = open_saves[open_saves.size() - 1];
				open_saves.delete(open_saves.size() - 1);
				close_at[j] = i;
				depth--;
			end
		end
		cur = 24'($urandom_range(0, OFF_MAX - 600000));
		for (int i = 0; i < n; i++) begin
			cur = cur + (($urandom_range(0, 9) == 0) ? 24'($urandom_range(33, 4096))
				: 24'($urandom_range(1, 32)));
			offs.insert(offs.size(), cur);
		end
		for (int i = 0; i < n; i++) begin
			if (close_at[i] >= 0)
				rests.insert(rests.size(), offs[close_at[i]]);
			else if ($urandom_range(0, 1) == 0)
				rests.insert(rests.size(), offs[n-1] + 1'b1);
			else
				rests.insert(rests.size(), 24'($urandom_range(0, OFF_MAX)));
			if (kinds[i] == OP_DRAW && $urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 7) == 0)
					tgts.insert(tgts.size(), offs[i] - 1'b1);
				tgts.insert(tgts.size(), offs[i]);
			end else if ($urandom_range(0, 11) == 0) begin
				tgts.insert(tgts.size(), offs[i]);
			end
		end
		put_word(ACT_CLEAR, 24'($urandom), 3'($urandom), 24'($urandom));
		foreach (tgts[i])
			put_word(ACT_PUSH, tgts[i], 3'($urandom), 24'($urandom));
		foreach (offs[i]) begin
			if ($urandom_range(0, 24) == 0)
				put_noise();
			put_command(offs[i], kinds[i], rests[i]);
		end
	endtask

	// fill the target queue past its depth, then consume parts of it
	task automatic run_fill();
		logic [OFF_W-1:0] tgts[$];
		logic [OFF_W-1:0] cur;
		cur = 24'($urandom_range(0, OFF_MAX - 10000));
		for (int i = 0; i < TARGET_DEPTH + 4; i++) begin
			cur = cur + 24'($urandom_range(1, 16));
			tgts.insert(tgts.size(), cur);
		end
		put_word(ACT_CLEAR, 24'($urandom), 3'($urandom), 24'($urandom));
		foreach (tgts[i])
			put_word(ACT_PUSH, tgts[i], 3'($urandom), 24'($urandom));
		put_command(tgts[0], OP_DRAW, 24'($urandom));
		put_command(tgts[100], OP_XFORM, 24'($urandom));
		put_command(tgts[101], OP_DRAW, 24'($urandom));
		put_command(tgts[TARGET_DEPTH + 3], OP_DRAW, 24'($urandom));
	endtask

	initial begin
		int seg;
		int quota;
		int r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_cull(1'b1);

		put_word(ACT_PUSH, 24'd10, OP_SAVE, 24'd0);
		put_word(ACT_PUSH, 24'd40, OP_SAVE, 24'd0);
		put_word(ACT_PUSH, OFF_MAX, OP_TOP_CODE, OFF_MAX);
		put_command(24'd0, OP_SAVE, 24'd50);
		put_command(24'd5, OP_XFORM, 24'd0);
		put_command(24'd10, OP_DRAW, 24'd0);
		put_command(24'd20, OP_DRAW, 24'd0);
		put_command(24'd30, OP_OTHER, 24'd0);
		put_command(24'd35, OP_TOP_CODE, OFF_MAX);
		// restore of a replayed save, skipping a stale target on the way
		put_command(24'd50, OP_RESTORE, 24'd0);
		put_command(24'd60, OP_RESTORE, 24'd0);
		put_command(24'd70, OP_SAVE, 24'd80);
		put_command(24'd75, OP_XFORM, 24'd0);
		put_command(24'd81, OP_RESTORE, 24'd0);
		put_command(24'd80, OP_RESTORE, 24'd0);
		put_command(OFF_MAX, OP_DRAW, 24'd0);
		// empty queue: draw at the all-ones offset never matches
		put_command(SENTINEL, OP_DRAW, 24'd0);
		put_word(ACT_IGNORED, OFF_MAX, OP_DRAW, OFF_MAX);
		put_word(ACT_CLEAR, 24'd0, OP_SAVE, 24'd0);
		put_command(24'd0, OP_XFORM, 24'd0);

		set_cull(1'b0);
		put_command(24'd123, OP_DRAW, 24'd0);
		put_word(ACT_PUSH, 24'd5, OP_SAVE, 24'd0);
		put_command(24'd6, OP_SAVE, 24'd9);
		put_command(24'd7, OP_OTHER, 24'd0);
		put_word(ACT_CLEAR, 24'd0, OP_SAVE, 24'd0);

		seg = 0;
		while (words_sent < WORD_GOAL) begin
			case (seg)
				0: set_cull(1'b1);
				1: set_cull(1'b0);
				2: set_cull(1'b1);
				default: set_cull($urandom_range(0, 3) != 0);
			endcase
			if (seg == 3)
				hold_go <= 1'b1;
			quota = words_sent + 180;
			if (quota > WORD_GOAL)
				quota = WORD_GOAL;
			if (seg == 0)
				run_list(140, 1'b1);
			else if (seg == 2)
				run_fill();
			while (words_sent < quota) begin
				r = $urandom_range(0, 29);
				if (r == 0)
					run_list(140, 1'b1);
				else if (r == 1)
					run_fill();
				else if (r < 5)
					put_noise();
				else
					run_list($urandom_range(4, 40), 1'b0);
			end
			seg++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
